### design/cwdt_pkg.sv
package cwdt_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_DIR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_OFFSET = 2'd2;

  // Register and field widths.
  localparam int unsigned PERIOD_W = 31;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned ZONE_W   = 18;
  localparam int unsigned MS_W     = 10;
  localparam int unsigned WORD_W   = 32;

  // Trim direction codes. Both negative codes subtract one per period.
  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_PLUS = 2'b01;

  // Shared restoring divider: dividend, remainder and step counter widths.
  localparam int unsigned DIV_W = 35;
  localparam int unsigned REM_W = 31;
  localparam int unsigned CNT_W = 6;

  // Signed width of the trimmed elapsed count and of the GMT carry sum.
  localparam int unsigned UP_W = 36;

  localparam logic [REM_W-1:0] MS_PER_SEC = 31'd1000;
  localparam logic [MS_W-1:0]  MS_MAX     = 10'd999;
  localparam logic [MS_W-1:0]  MS_FULL    = 10'd1000;

  // A negative carry sum wraps modulo 2^64. With 2^64 = 1000 * WRAP_Q + 616,
  // 2^64 - m = 1000 * (WRAP_Q + 1) - (m + WRAP_PAD).
  localparam logic [WORD_W-1:0] WRAP_Q   = 32'd1271310319;
  localparam logic [WORD_W-1:0] WRAP_Q1  = 32'd1271310320;
  localparam logic [UP_W-1:0]   WRAP_PAD = 36'd384;

  // Sync tolerance in milliseconds, and its complement within one second.
  localparam logic signed [11:0] TOL_MS  = 12'sd250;
  localparam logic signed [11:0] NEAR_MS = 12'sd750;

  // Relation of network seconds to GMT seconds.
  localparam logic [1:0] REL_EQ     = 2'd0;
  localparam logic [1:0] REL_AHEAD  = 2'd1;
  localparam logic [1:0] REL_BEHIND = 2'd2;
  localparam logic [1:0] REL_FAR    = 2'd3;

endpackage

### design/cwdt_ifs.sv
interface cwdt_item_if
  import cwdt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              action;
  logic [WORD_W-1:0] raw_ms;
  logic [WORD_W-1:0] sync_seconds;
  logic [MS_W-1:0]   sync_ms;

  modport source (output valid, action, raw_ms, sync_seconds, sync_ms, input ready);
  modport sink   (input valid, action, raw_ms, sync_seconds, sync_ms, output ready);
endinterface

interface cwdt_result_if
  import cwdt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] adjusted_ms;
  logic [WORD_W-1:0] gmt_seconds;
  logic [MS_W-1:0]   gmt_ms;
  logic [WORD_W-1:0] local_seconds;
  logic [WORD_W-1:0] uptime_seconds;
  logic              resynced;

  modport source (output valid, adjusted_ms, gmt_seconds, gmt_ms, local_seconds,
                  uptime_seconds, resynced, input ready);
  modport sink   (input valid, adjusted_ms, gmt_seconds, gmt_ms, local_seconds,
                  uptime_seconds, resynced, output ready);
endinterface

### design/clock_with_drift_trim.sv
// Channel   Dir  Payload
// item      in   action, raw_ms, sync_seconds, sync_ms
// result    out  adjusted_ms, gmt_seconds, gmt_ms, local_seconds, uptime_seconds, resynced
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// One item at a time. A reading equal to the last one skips the divider and goes to the
// result register (through the sync compare and set states for a sync). Otherwise the
// shared 35-step restoring divider runs for the uptime carry, the trim period (only when
// trim_period is nonzero) and the GMT carry.
// Reset (synchronous, rst high) clears all time state and loads the register defaults.
// A finished result waits in the output register; the next item is taken meanwhile.
module clock_with_drift_trim
  import cwdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cwdt_item_if.sink             item,
  cwdt_result_if.source         result
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_UP_DIV   = 4'd2;
  localparam logic [3:0] S_UP_POST  = 4'd3;
  localparam logic [3:0] S_TR_DIV   = 4'd4;
  localparam logic [3:0] S_TR_POST  = 4'd5;
  localparam logic [3:0] S_GMT_SUM  = 4'd6;
  localparam logic [3:0] S_GMT_LOAD = 4'd7;
  localparam logic [3:0] S_GMT_DIV  = 4'd8;
  localparam logic [3:0] S_GMT_POST = 4'd9;
  localparam logic [3:0] S_GMT_ADD  = 4'd10;
  localparam logic [3:0] S_SYNC_CMP = 4'd11;
  localparam logic [3:0] S_SYNC_SET = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;

  // Configuration registers.
  logic [PERIOD_W-1:0] trim_period;
  logic [DIR_W-1:0]    trim_direction;
  logic [ZONE_W-1:0]   zone_offset;

  // Time state.
  logic [WORD_W-1:0]   last_reading;
  logic [MS_W-1:0]     uptime_sub_ms;
  logic [WORD_W-1:0]   uptime_secs;
  logic [PERIOD_W-1:0] trim_position;
  logic [WORD_W-1:0]   trimmed_ms;
  logic [MS_W-1:0]     gmt_sub_ms;
  logic [WORD_W-1:0]   gmt_secs;

  // Current item.
  logic [3:0]          state;
  logic                act;
  logic [WORD_W-1:0]   s_sec;
  logic [MS_W-1:0]     s_ms;
  logic [WORD_W-1:0]   delta;
  logic                resync;

  // Working registers.
  logic signed [UP_W-1:0] up;
  logic signed [UP_W-1:0] gsum;
  logic                   neg;
  logic [WORD_W-1:0]      gstep;
  logic [1:0]             rel;
  logic signed [11:0]     dm;

  // Shared divider.
  logic [DIV_W-1:0] dq;
  logic [REM_W-1:0] drem;
  logic [REM_W-1:0] dsor;
  logic [CNT_W-1:0] cnt;

  logic [REM_W:0]   trial;
  logic [REM_W+1:0] tdiff;
  logic             fits;
  logic [REM_W-1:0] drem_step;
  logic [DIV_W-1:0] dq_step;

  // Output register.
  logic              out_valid;
  logic [WORD_W-1:0] out_adjusted;
  logic [WORD_W-1:0] out_gmt_secs;
  logic [MS_W-1:0]   out_gmt_ms;
  logic [WORD_W-1:0] out_local;
  logic [WORD_W-1:0] out_uptime;
  logic              out_resync;

  logic              out_free;
  logic              accept;
  logic [UP_W-1:0]   wide_mag;
  logic              far;
  logic [MS_W-1:0]   s_ms_sat;
  logic [WORD_W:0]   sec_diff;

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign trial     = {drem, dq[DIV_W-1]};
  assign tdiff     = {1'b0, trial} - {2'b00, dsor};
  assign fits      = !tdiff[REM_W+1];
  assign drem_step = fits ? tdiff[REM_W-1:0] : trial[REM_W-1:0];
  assign dq_step   = {dq[DIV_W-2:0], fits};

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;
  assign s_ms_sat   = (item.sync_ms > MS_MAX) ? MS_MAX : item.sync_ms;
  assign wide_mag   = gsum[UP_W-1] ? (WRAP_PAD - UP_W'(gsum)) : UP_W'(gsum);
  assign sec_diff   = {1'b0, s_sec} - {1'b0, gmt_secs};

  always_comb begin
    unique case (rel)
      REL_EQ:     far = (dm > TOL_MS) || (dm < -TOL_MS);
      REL_AHEAD:  far = (dm > -NEAR_MS);
      REL_BEHIND: far = (dm < NEAR_MS);
      default:    far = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_period    <= '0;
      trim_direction <= DIR_PLUS;
      zone_offset    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIM_PERIOD: trim_period    <= cfg_data[PERIOD_W-1:0];
        CFG_TRIM_DIR:    trim_direction <= cfg_data[DIR_W-1:0];
        CFG_ZONE_OFFSET: zone_offset    <= cfg_data[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_reading  <= '0;
      uptime_sub_ms <= '0;
      uptime_secs   <= '0;
      trim_position <= '0;
      trimmed_ms    <= '0;
      gmt_sub_ms    <= '0;
      gmt_secs      <= '0;
      resync        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act          <= item.action;
            s_sec        <= item.sync_seconds;
            s_ms         <= s_ms_sat;
            delta        <= item.raw_ms - last_reading;
            last_reading <= item.raw_ms;
            resync       <= 1'b0;
            state        <= S_START;
          end
        end
        S_START: begin
          if (delta == '0) begin
            state <= act ? S_SYNC_CMP : S_FIN;
          end else begin
            dq    <= DIV_W'(uptime_sub_ms) + DIV_W'(delta);
            drem  <= '0;
            dsor  <= MS_PER_SEC;
            cnt   <= CNT_W'(DIV_W - 1);
            state <= S_UP_DIV;
          end
        end
        S_UP_DIV, S_TR_DIV, S_GMT_DIV: begin
          dq   <= dq_step;
          drem <= drem_step;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            unique case (state)
              S_UP_DIV: state <= S_UP_POST;
              S_TR_DIV: state <= S_TR_POST;
              default:  state <= S_GMT_POST;
            endcase
          end
        end
        S_UP_POST: begin
          uptime_secs   <= uptime_secs + dq[WORD_W-1:0];
          uptime_sub_ms <= drem[MS_W-1:0];
          if (trim_period != '0) begin
            dq    <= DIV_W'(trim_position) + DIV_W'(delta);
            drem  <= '0;
            dsor  <= trim_period;
            cnt   <= CNT_W'(DIV_W - 1);
            state <= S_TR_DIV;
          end else begin
            up    <= $signed(UP_W'(delta));
            state <= S_GMT_SUM;
          end
        end
        S_TR_POST: begin
          trim_position <= drem;
          unique case (trim_direction)
            DIR_NONE: up <= $signed(UP_W'(delta));
            DIR_PLUS: up <= $signed(UP_W'(delta)) + $signed(UP_W'(dq));
            default:  up <= $signed(UP_W'(delta)) - $signed(UP_W'(dq));
          endcase
          state <= S_GMT_SUM;
        end
        S_GMT_SUM: begin
          trimmed_ms <= trimmed_ms + up[WORD_W-1:0];
          gsum       <= $signed(UP_W'(gmt_sub_ms)) + up;
          state      <= S_GMT_LOAD;
        end
        S_GMT_LOAD: begin
          neg   <= gsum[UP_W-1];
          dq    <= wide_mag[DIV_W-1:0];
          drem  <= '0;
          dsor  <= MS_PER_SEC;
          cnt   <= CNT_W'(DIV_W - 1);
          state <= S_GMT_DIV;
        end
        S_GMT_POST: begin
          // A negative sum is seen modulo 2^64, so quotient and remainder fold back.
          priority if (!neg) begin
            gstep      <= dq[WORD_W-1:0];
            gmt_sub_ms <= drem[MS_W-1:0];
          end else if (drem == '0) begin
            gstep      <= WRAP_Q1 - dq[WORD_W-1:0];
            gmt_sub_ms <= '0;
          end else begin
            gstep      <= WRAP_Q - dq[WORD_W-1:0];
            gmt_sub_ms <= MS_FULL - drem[MS_W-1:0];
          end
          state <= S_GMT_ADD;
        end
        S_GMT_ADD: begin
          gmt_secs <= gmt_secs + gstep;
          state    <= act ? S_SYNC_CMP : S_FIN;
        end
        S_SYNC_CMP: begin
          // Seconds more than one apart are always beyond the tolerance.
          if (sec_diff == '0) begin
            rel <= REL_EQ;
          end else if (sec_diff == (WORD_W+1)'(1)) begin
            rel <= REL_AHEAD;
          end else if (sec_diff == '1) begin
            rel <= REL_BEHIND;
          end else begin
            rel <= REL_FAR;
          end
          dm    <= $signed({2'b00, s_ms}) - $signed({2'b00, gmt_sub_ms});
          state <= S_SYNC_SET;
        end
        S_SYNC_SET: begin
          if (far) begin
            gmt_secs   <= s_sec;
            gmt_sub_ms <= s_ms;
            resync     <= 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_adjusted <= trimmed_ms;
      out_gmt_secs <= gmt_secs;
      out_gmt_ms   <= gmt_sub_ms;
      out_local    <= gmt_secs + {{(WORD_W-ZONE_W){zone_offset[ZONE_W-1]}}, zone_offset};
      out_uptime   <= uptime_secs;
      out_resync   <= resync;
    end
  end

  assign result.valid          = out_valid;
  assign result.adjusted_ms    = out_adjusted;
  assign result.gmt_seconds    = out_gmt_secs;
  assign result.gmt_ms         = out_gmt_ms;
  assign result.local_seconds  = out_local;
  assign result.uptime_seconds = out_uptime;
  assign result.resynced       = out_resync;

endmodule

### design/cwdt_checker.sv
module cwdt_checker
  import cwdt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [WORD_W-1:0] adjusted_ms,
  input logic [WORD_W-1:0] gmt_seconds,
  input logic [MS_W-1:0]   gmt_ms,
  input logic              resynced
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(adjusted_ms) && $stable(gmt_seconds) &&
       $stable(gmt_ms) && $stable(resynced)))
    else $error("stalled result changed");

  // One item at a time: after a transfer in, the block is busy.
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while busy");

  // No result can appear in the cycle right after a transfer in.
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !$rose(result_valid))
    else $error("result too early");

  // Reset leaves the block idle with an empty output register.
  assert property (@(posedge clk)
    $past(rst) |-> (!result_valid && item_ready))
    else $error("bad state after reset");

  // The GMT millisecond position stays within one second.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (gmt_ms <= MS_MAX))
    else $error("gmt_ms out of range");

endmodule

bind clock_with_drift_trim cwdt_checker u_cwdt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .adjusted_ms  (result.adjusted_ms),
  .gmt_seconds  (result.gmt_seconds),
  .gmt_ms       (result.gmt_ms),
  .resynced     (result.resynced)
);
